FILE: sv/aes128_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// S-box tables, GF(2^8) helpers and controller state type.
// ----------------------------------------------------------------------------
package aes128_pkg;

  typedef enum logic [2:0] {
    ST_KEXP,
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic CMD_DECRYPT = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

FILE: sv/aes128_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Encrypts or decrypts one 128-bit block per item with a shared round unit.
// ----------------------------------------------------------------------------
// Round keys live in a 11 x 128-bit synchronous memory (one round key per
// row, registered read). After reset and after every key write the block
// expands the key, one round key per cycle, and takes no item meanwhile.
// The first round key is fetched in the cycle an item is accepted. The
// result reaches the output register through the initial key add, ten
// rounds through the one round unit (one round per cycle, the next round
// key prefetched each cycle), and the done state that moves the result out.
// A new item is accepted only in the idle state, once the previous result
// has left the done state. A result waits in its own output register; a
// finished block waits for that register while it is full and stalled, and
// no item is accepted meanwhile.
module aes128_block_cipher #(
  parameter int ROUND_COUNT = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [63:0] block_high,
  input  wire logic [63:0] block_low,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_high,
  output logic [63:0]      result_low,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int RK_ROWS = ROUND_COUNT + 1;
  localparam int RW      = $clog2(RK_ROWS);

  aes128_pkg::state_t state, state_next;

  logic [127:0] rk_mem [RK_ROWS];
  logic [127:0] rk_rdata;
  logic [RW-1:0] rk_raddr;
  logic [RW-1:0] rk_ridx;
  logic          rk_dec;
  logic          rk_we;
  logic [RW-1:0] rk_waddr;
  logic [127:0] rk_wdata;

  logic [63:0]   key_high, key_low;
  logic [127:0]  kexp_key;
  logic [7:0]    rcon;
  logic [RW-1:0] kcnt;
  logic [RW-1:0] rnd;
  logic [127:0]  st;
  logic          dec;
  logic          out_full;
  logic          out_load;

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_rdata <= rk_mem[rk_raddr];
  end

  // next round key
  logic [31:0] w0, w1, w2, w3, tw;
  logic [127:0] kexp_nx;
  always_comb begin
    w0 = kexp_key[127:96];
    w1 = kexp_key[95:64];
    w2 = kexp_key[63:32];
    w3 = kexp_key[31:0];
    tw = aes128_pkg::sub_word({w3[23:0], w3[31:24]}) ^ {rcon, 24'h0};
    kexp_nx[127:96] = w0 ^ tw;
    kexp_nx[95:64]  = w1 ^ w0 ^ tw;
    kexp_nx[63:32]  = w2 ^ w1 ^ w0 ^ tw;
    kexp_nx[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ tw;
  end

  // round unit; byte n at bits 127-8n
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mx [16];
  logic [7:0] ak [16];
  logic [127:0] rnd_out;
  logic last;
  always_comb begin
    last = (rnd == RW'(ROUND_COUNT));
    for (int n = 0; n < 16; n++) sb[n] = st[127-8*n -: 8];
    if (!dec) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          sr[r+4*c] = aes128_pkg::SBOX[sb[r+4*((c+r)&3)]];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          mx[4*c+r] = aes128_pkg::gmul(sr[4*c+r], 8'd2) ^
                      aes128_pkg::gmul(sr[4*c+((r+1)&3)], 8'd3) ^
                      sr[4*c+((r+2)&3)] ^ sr[4*c+((r+3)&3)];
      for (int n = 0; n < 16; n++)
        ak[n] = (last ? sr[n] : mx[n]) ^ rk_rdata[127-8*n -: 8];
    end else begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          sr[r+4*((c+r)&3)] = aes128_pkg::INV_SBOX[sb[r+4*c]];
      for (int n = 0; n < 16; n++) ak[n] = sr[n] ^ rk_rdata[127-8*n -: 8];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          mx[4*c+r] = aes128_pkg::gmul(ak[4*c+r], 8'd14) ^
                      aes128_pkg::gmul(ak[4*c+((r+1)&3)], 8'd11) ^
                      aes128_pkg::gmul(ak[4*c+((r+2)&3)], 8'd13) ^
                      aes128_pkg::gmul(ak[4*c+((r+3)&3)], 8'd9);
      if (!last) for (int n = 0; n < 16; n++) ak[n] = mx[n];
    end
    for (int n = 0; n < 16; n++) rnd_out[127-8*n -: 8] = ak[n];
  end

  assign cfg_ready = (state == aes128_pkg::ST_IDLE);
  assign in_stall  = !((state == aes128_pkg::ST_IDLE) && !cfg_valid);
  assign out_valid = out_full;
  assign out_load  = (state == aes128_pkg::ST_DONE) && (!out_full || !out_stall);

  always_comb begin
    state_next = state;
    if ((state == aes128_pkg::ST_LOAD || state == aes128_pkg::ST_ROUND) &&
        rnd < RW'(ROUND_COUNT))
      rk_ridx = rnd + RW'(1);
    else
      rk_ridx = '0;
    if (state == aes128_pkg::ST_IDLE) rk_dec = (command == aes128_pkg::CMD_DECRYPT);
    else rk_dec = dec;
    rk_raddr   = rk_dec ? RW'(ROUND_COUNT) - rk_ridx : rk_ridx;
    rk_we      = 1'b0;
    rk_waddr   = kcnt;
    rk_wdata   = kexp_key;
    case (state)
      aes128_pkg::ST_KEXP: begin
        rk_we = 1'b1;
        if (kcnt == RW'(ROUND_COUNT)) state_next = aes128_pkg::ST_IDLE;
      end
      aes128_pkg::ST_IDLE: begin
        if (cfg_valid) state_next = aes128_pkg::ST_KEXP;
        else if (in_valid && !in_stall) state_next = aes128_pkg::ST_LOAD;
      end
      aes128_pkg::ST_LOAD: state_next = aes128_pkg::ST_ROUND;
      aes128_pkg::ST_ROUND: if (last) state_next = aes128_pkg::ST_DONE;
      aes128_pkg::ST_DONE: if (out_load) state_next = aes128_pkg::ST_IDLE;
      default: state_next = aes128_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= aes128_pkg::ST_KEXP;
      key_high <= 64'h0;
      key_low  <= 64'h0;
      kexp_key <= 128'h0;
      rcon     <= 8'h01;
      kcnt     <= '0;
      rnd      <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_full <= 1'b1;
      else if (out_full && !out_stall) out_full <= 1'b0;
      case (state)
        aes128_pkg::ST_KEXP: begin
          kexp_key <= kexp_nx;
          rcon     <= aes128_pkg::xtime(rcon);
          kcnt     <= kcnt + RW'(1);
        end
        aes128_pkg::ST_IDLE: begin
          rnd <= '0;
          if (cfg_valid) begin
            kcnt <= '0;
            rcon <= 8'h01;
            if (cfg_index) begin
              key_low  <= cfg_data;
              kexp_key <= {key_high, cfg_data};
            end else begin
              key_high <= cfg_data;
              kexp_key <= {cfg_data, key_low};
            end
          end
        end
        aes128_pkg::ST_LOAD: rnd <= rnd + RW'(1);
        aes128_pkg::ST_ROUND: rnd <= rnd + RW'(1);
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == aes128_pkg::ST_IDLE && in_valid && !in_stall && !cfg_valid) begin
      st  <= {block_high, block_low};
      dec <= (command == aes128_pkg::CMD_DECRYPT);
    end else if (state == aes128_pkg::ST_LOAD) begin
      st <= st ^ rk_rdata;
    end else if (state == aes128_pkg::ST_ROUND) begin
      st <= rnd_out;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_high <= st[127:64];
      result_low  <= st[63:0];
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != aes128_pkg::ST_IDLE) |-> in_stall)
    else $error("item accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_high) && $stable(result_low)))
    else $error("result changed while stalled");
  a_done_sets: assert property (@(posedge clk) disable iff (rst)
    (state == aes128_pkg::ST_DONE) |=> out_valid)
    else $error("result not presented");
`endif

endmodule
`default_nettype wire
